// File: src/gas_sensor_ppm_converter_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gas sensor ppm converter
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is held.
// ---------------------------------------------------------------------------
`ifndef GAS_SENSOR_PPM_CONVERTER_CORE_ASSERT_SVH
`define GAS_SENSOR_PPM_CONVERTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsp assertion failed");

`endif

// File: src/gsp_pkg.sv
// ---------------------------------------------------------------------------
// Gas sensor ppm converter package
// Shared constants, payload types, status codes and the exp factor table.
// ---------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  // Sensor and calibration constants.
  localparam int FRAC_BITS        = 16;
  localparam int ADC_FULL_SCALE   = 1023;
  localparam int CAL_SAMPLES      = 10;
  localparam int CLEAN_AIR_FACTOR = 10;
  localparam int CAL_DIVISOR      = CAL_SAMPLES * CLEAN_AIR_FACTOR;

  // Serial divider geometry.
  localparam int DIV_W     = 48;
  localparam int DSR_W     = 32;
  localparam int DIV_CNT_W = 6;

  // Conversion constants in Q16.
  localparam logic signed [15:0] LOG10_OF_2 = 16'sd19728;
  localparam logic signed [18:0] LOG2_OF_10 = 19'sd217706;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_MEASURED     = 3'd0,
    ST_CAL_TAKEN    = 3'd1,
    ST_CAL_DONE     = 3'd2,
    ST_ZERO_SAMPLE  = 3'd3,
    ST_UNCALIBRATED = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_INTERCEPT    = 3'd0,
    CFG_LPG_OFFSET   = 3'd1,
    CFG_LPG_SLOPE    = 3'd2,
    CFG_CO_OFFSET    = 3'd3,
    CFG_CO_SLOPE     = 3'd4,
    CFG_SMOKE_OFFSET = 3'd5,
    CFG_SMOKE_SLOPE  = 3'd6,
    CFG_PPM_LIMIT    = 3'd7
  } cfg_index_t;

  // Register values after reset.
  localparam logic [15:0] RST_INTERCEPT    = 16'd9421;
  localparam logic [15:0] RST_LPG_OFFSET   = 16'd860;
  localparam logic [15:0] RST_LPG_SLOPE    = 16'hF87B;
  localparam logic [15:0] RST_CO_OFFSET    = 16'd2949;
  localparam logic [15:0] RST_CO_SLOPE     = 16'hFA8F;
  localparam logic [15:0] RST_SMOKE_OFFSET = 16'd2171;
  localparam logic [15:0] RST_SMOKE_SLOPE  = 16'hF8F6;
  localparam logic [15:0] RST_PPM_LIMIT    = 16'd9000;

  // Request payloads.
  typedef struct packed {
    logic       operation;
    logic [9:0] sample;
  } gsp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] lpg_ppm;
    logic [15:0] co_ppm;
    logic [15:0] smoke_ppm;
  } gsp_out_t;

  typedef logic [30:0] fac_tab_t [16];

  // Truncated integer square root, used only at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factors 2^(2^-i) in Q30 for i = 1 to 16, by repeated square roots.
  function automatic fac_tab_t fac_table();
    fac_tab_t    tab;
    logic [63:0] fac;
    fac = 64'd1 << 31;
    for (int i = 0; i < 16; i++) begin
      fac    = isqrt64(fac << 30);
      tab[i] = fac[30:0];
    end
    return tab;
  endfunction

  localparam fac_tab_t EXP_FAC = fac_table();

endpackage

`default_nettype wire

// File: src/gas_sensor_ppm_converter_core.sv
// ---------------------------------------------------------------------------
// Gas sensor ppm converter core
// Converts ADC samples of a gas sensor divider into LPG, CO and smoke ppm.
// ---------------------------------------------------------------------------
// Usage: requests arrive on in_valid/in_stall with an operation bit and a
// 10-bit sample; one result leaves on out_valid/out_stall per request.
// Calibration requests accumulate the resistance ratio; every tenth one sets
// the clean-air reference. Measure requests give three ppm values.
// One request is worked on at a time. The time taken is set by the shared
// bit-serial divider, one quotient bit per cycle, used for the ratio, the
// clean-air reference, the normalised ratio and each of the three slope
// divisions, plus the 16-step log and exp units.
// The user must write registers on the cfg_ port only while the block is
// idle; the block itself does not enforce this.
// Reset clears the calibration state and loads the default curve registers.
// A new request is taken while a finished result waits; when the receiver
// stalls, the next result waits in its final state until the output frees.
// ---------------------------------------------------------------------------
`default_nettype none

module gas_sensor_ppm_converter_core import gsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire gsp_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output gsp_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

`include "gas_sensor_ppm_converter_core_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_RATIO,
    S_EVAL,
    S_RO,
    S_R,
    S_LOG,
    S_GAS,
    S_GDIV,
    S_EXP,
    S_DONE
  } state_t;

  localparam logic [9:0] ADC_FS = 10'(ADC_FULL_SCALE);

  state_t             state_r;
  logic               op_r;
  logic [31:0]        ratio_r;
  logic [DIV_W-1:0]   r_r;
  logic signed [23:0] lg_r;
  logic [1:0]         gas_r;
  logic               neg_r;
  logic [2:0]         status_r;
  logic [15:0]        lpg_r;
  logic [15:0]        co_r;
  logic [15:0]        smoke_r;
  logic [31:0]        cal_sum_r;
  logic [3:0]         cal_count_r;
  logic [31:0]        ro_r;
  logic               ro_valid_r;
  logic               out_valid_r;
  gsp_out_t           out_data_r;

  logic [15:0] intercept_r;
  logic [15:0] lpg_off_r;
  logic [15:0] lpg_slp_r;
  logic [15:0] co_off_r;
  logic [15:0] co_slp_r;
  logic [15:0] smoke_off_r;
  logic [15:0] smoke_slp_r;
  logic [15:0] limit_r;

  logic               div_start_r;
  logic [DIV_W-1:0]   div_dvd_r;
  logic [DSR_W-1:0]   div_dsr_r;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic               log_start_r;
  logic               log_done;
  logic signed [23:0] log_out;
  logic               exp_start_r;
  logic signed [22:0] exp_t_r;
  logic               exp_done;
  logic [15:0]        exp_ppm;

  logic               in_take;
  logic               out_free;
  logic [15:0]        sel_off;
  logic [15:0]        sel_slp;
  logic [15:0]        slp_mag;
  logic signed [24:0] diff;
  logic [24:0]        diff_mag;
  logic [32:0]        sum_wide;
  logic [31:0]        sum_sat;
  logic [3:0]         cnt_nxt;
  logic [39:0]        q_signed;
  logic [39:0]        t_wide;
  logic signed [22:0] t_clamp;
  logic [15:0]        gas_ppm_nxt;

  // Serial arithmetic units.
  gsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dsr_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  gsp_log u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start_r),
    .r     (r_r),
    .done  (log_done),
    .log10 (log_out)
  );

  gsp_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (exp_start_r),
    .t     (exp_t_r),
    .limit (limit_r),
    .done  (exp_done),
    .ppm   (exp_ppm)
  );

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Curve selection for the gas in progress.
  always_comb begin
    case (gas_r)
      2'd0:    begin sel_off = lpg_off_r;   sel_slp = lpg_slp_r;   end
      2'd1:    begin sel_off = co_off_r;    sel_slp = co_slp_r;    end
      default: begin sel_off = smoke_off_r; sel_slp = smoke_slp_r; end
    endcase
  end

  // Slope division operands: magnitudes of (log10 - 16b) * 4096 and of m.
  always_comb begin
    slp_mag  = sel_slp[15] ? (~sel_slp + 16'd1) : sel_slp;
    diff     = $signed({lg_r[23], lg_r}) - $signed({{5{sel_off[15]}}, sel_off, 4'b0});
    diff_mag = diff[24] ? (~diff + 25'd1) : diff;
  end

  // Signed quotient plus 16a, clamped to a range that keeps the outcome.
  always_comb begin
    q_signed = neg_r ? (~{2'b0, div_quo[37:0]} + 40'd1) : {2'b0, div_quo[37:0]};
    t_wide   = q_signed + {{20{intercept_r[15]}}, intercept_r, 4'b0};
    if (!t_wide[39] && (|t_wide[38:22])) begin
      t_clamp = 23'sh3FFFFF;
    end else if (t_wide[39] && !(&t_wide[38:22])) begin
      t_clamp = -23'sh400000;
    end else begin
      t_clamp = $signed(t_wide[22:0]);
    end
  end

  // Calibration accumulator with saturation.
  always_comb begin
    sum_wide = {1'b0, cal_sum_r} + {1'b0, ratio_r};
    sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
    cnt_nxt  = cal_count_r + 4'd1;
  end

  // Short-cut ppm for a zero slope or a zero ratio.
  always_comb begin
    if (sel_slp == 16'd0) begin
      gas_ppm_nxt = limit_r;
    end else begin
      gas_ppm_nxt = sel_slp[15] ? limit_r : 16'd0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intercept_r <= RST_INTERCEPT;
      lpg_off_r   <= RST_LPG_OFFSET;
      lpg_slp_r   <= RST_LPG_SLOPE;
      co_off_r    <= RST_CO_OFFSET;
      co_slp_r    <= RST_CO_SLOPE;
      smoke_off_r <= RST_SMOKE_OFFSET;
      smoke_slp_r <= RST_SMOKE_SLOPE;
      limit_r     <= RST_PPM_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERCEPT:    intercept_r <= cfg_data;
        CFG_LPG_OFFSET:   lpg_off_r   <= cfg_data;
        CFG_LPG_SLOPE:    lpg_slp_r   <= cfg_data;
        CFG_CO_OFFSET:    co_off_r    <= cfg_data;
        CFG_CO_SLOPE:     co_slp_r    <= cfg_data;
        CFG_SMOKE_OFFSET: smoke_off_r <= cfg_data;
        CFG_SMOKE_SLOPE:  smoke_slp_r <= cfg_data;
        CFG_PPM_LIMIT:    limit_r     <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cal_sum_r   <= '0;
      cal_count_r <= '0;
      ro_r        <= '0;
      ro_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      log_start_r <= 1'b0;
      exp_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      log_start_r <= 1'b0;
      exp_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            op_r    <= in_data.operation;
            lpg_r   <= '0;
            co_r    <= '0;
            smoke_r <= '0;
            if (in_data.sample == 10'd0) begin
              status_r <= ST_ZERO_SAMPLE;
              state_r  <= S_DONE;
            end else if (in_data.sample >= ADC_FS) begin
              ratio_r <= '0;
              state_r <= S_EVAL;
            end else begin
              div_dvd_r   <= {22'b0, ADC_FS - in_data.sample, 16'b0};
              div_dsr_r   <= {22'b0, in_data.sample};
              div_start_r <= 1'b1;
              state_r     <= S_RATIO;
            end
          end
        end
        S_RATIO: begin
          if (div_done) begin
            ratio_r <= div_quo[31:0];
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (op_r) begin
            if (cnt_nxt >= 4'(CAL_SAMPLES)) begin
              cal_sum_r   <= '0;
              cal_count_r <= '0;
              div_dvd_r   <= {16'b0, sum_sat};
              div_dsr_r   <= DSR_W'(CAL_DIVISOR);
              div_start_r <= 1'b1;
              state_r     <= S_RO;
            end else begin
              cal_sum_r   <= sum_sat;
              cal_count_r <= cnt_nxt;
              status_r    <= ST_CAL_TAKEN;
              state_r     <= S_DONE;
            end
          end else if (!ro_valid_r || (ro_r == 32'd0)) begin
            status_r <= ST_UNCALIBRATED;
            state_r  <= S_DONE;
          end else begin
            div_dvd_r   <= {ratio_r, 16'b0};
            div_dsr_r   <= ro_r;
            div_start_r <= 1'b1;
            state_r     <= S_R;
          end
        end
        S_RO: begin
          if (div_done) begin
            ro_r       <= div_quo[31:0];
            ro_valid_r <= 1'b1;
            status_r   <= ST_CAL_DONE;
            state_r    <= S_DONE;
          end
        end
        S_R: begin
          if (div_done) begin
            r_r   <= div_quo;
            gas_r <= 2'd0;
            if (div_quo == '0) begin
              state_r <= S_GAS;
            end else begin
              log_start_r <= 1'b1;
              state_r     <= S_LOG;
            end
          end
        end
        S_LOG: begin
          if (log_done) begin
            lg_r    <= log_out;
            state_r <= S_GAS;
          end
        end
        // Per gas: short-cut cases settle here, others go through the units.
        S_GAS: begin
          if ((sel_slp == 16'd0) || (r_r == '0)) begin
            case (gas_r)
              2'd0:    lpg_r   <= gas_ppm_nxt;
              2'd1:    co_r    <= gas_ppm_nxt;
              default: smoke_r <= gas_ppm_nxt;
            endcase
            if (gas_r == 2'd2) begin
              status_r <= ST_MEASURED;
              state_r  <= S_DONE;
            end else begin
              gas_r <= gas_r + 2'd1;
            end
          end else begin
            div_dvd_r   <= {11'b0, diff_mag, 12'b0};
            div_dsr_r   <= {16'b0, slp_mag};
            neg_r       <= diff[24] ^ sel_slp[15];
            div_start_r <= 1'b1;
            state_r     <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (div_done) begin
            exp_t_r     <= t_clamp;
            exp_start_r <= 1'b1;
            state_r     <= S_EXP;
          end
        end
        S_EXP: begin
          if (exp_done) begin
            case (gas_r)
              2'd0:    lpg_r   <= exp_ppm;
              2'd1:    co_r    <= exp_ppm;
              default: smoke_r <= exp_ppm;
            endcase
            if (gas_r == 2'd2) begin
              status_r <= ST_MEASURED;
              state_r  <= S_DONE;
            end else begin
              gas_r   <= gas_r + 2'd1;
              state_r <= S_GAS;
            end
          end
        end
        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (out_free) begin
            out_data_r.status    <= status_r;
            out_data_r.lpg_ppm   <= lpg_r;
            out_data_r.co_ppm    <= co_r;
            out_data_r.smoke_ppm <= smoke_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Once calibrated, the block stays calibrated.
  `GSP_ASSERT_NEXT(a_ro_kept, clk, rst_n, ro_valid_r, ro_valid_r)
  // The sample count never reaches the series length between requests.
  `GSP_ASSERT_SAME(a_cnt_range, clk, rst_n, 1'b1, cal_count_r < 4'(CAL_SAMPLES))
  // Only a measured result carries concentrations.
  `GSP_ASSERT_SAME(a_ppm_zero, clk, rst_n,
    out_valid_r && (out_data_r.status != ST_MEASURED),
    (out_data_r.lpg_ppm == 16'd0) && (out_data_r.co_ppm == 16'd0) && (out_data_r.smoke_ppm == 16'd0))

endmodule

`default_nettype wire

// File: src/gsp_div.sv
// ---------------------------------------------------------------------------
// Bit-serial restoring divider
// Unsigned 48 by 32 bit division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gsp_div import gsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DSR_W-1:0]     rem_r;
  logic [DSR_W-1:0]     dsr_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DSR_W:0]       shifted;
  logic [DSR_W:0]       diff;
  logic                 ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: src/gsp_log.sv
// ---------------------------------------------------------------------------
// Serial log10 unit
// Normalises the ratio one bit a cycle, then builds 16 log2 fraction bits
// by repeated squaring and scales the result to log10 in Q16.
// ---------------------------------------------------------------------------
`default_nettype none

module gsp_log import gsp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] r,
  output logic                  done,
  output logic signed [23:0]    log10
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_NORM,
    L_SQ,
    L_ADJ,
    L_SCALE,
    L_FIN
  } lstate_t;

  lstate_t              state_r;
  logic                 done_r;
  logic [DIV_W-1:0]     x_r;
  logic [5:0]           sh_r;
  logic [30:0]          mant_r;
  logic [61:0]          prod_r;
  logic [15:0]          frac_r;
  logic [3:0]           it_r;
  logic signed [38:0]   scale_r;
  logic signed [23:0]   log_r;
  logic [31:0]          sq;
  logic signed [6:0]    int_part;
  logic signed [22:0]   l2;

  // Squared mantissa and the log2 value in Q16.
  always_comb begin
    sq       = prod_r[61:30];
    int_part = 7'sd31 - $signed({1'b0, sh_r});
    l2       = $signed({int_part, frac_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            x_r     <= r;
            sh_r    <= '0;
            state_r <= L_NORM;
          end
        end
        // Shift until the leading one reaches the top bit.
        L_NORM: begin
          if (x_r[DIV_W-1]) begin
            mant_r  <= x_r[DIV_W-1:DIV_W-31];
            frac_r  <= '0;
            it_r    <= '0;
            state_r <= L_SQ;
          end else begin
            x_r  <= {x_r[DIV_W-2:0], 1'b0};
            sh_r <= sh_r + 1'b1;
          end
        end
        L_SQ: begin
          prod_r  <= mant_r * mant_r;
          state_r <= L_ADJ;
        end
        // A square of two or more gives a one bit and is halved.
        L_ADJ: begin
          mant_r <= sq[31] ? sq[31:1] : sq[30:0];
          frac_r <= {frac_r[14:0], sq[31]};
          it_r   <= it_r + 1'b1;
          state_r <= (it_r == 4'd15) ? L_SCALE : L_SQ;
        end
        L_SCALE: begin
          scale_r <= l2 * LOG10_OF_2;
          state_r <= L_FIN;
        end
        L_FIN: begin
          log_r   <= {scale_r[38], scale_r[38:16]};
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign log10 = log_r;

endmodule

`default_nettype wire

// File: src/gsp_exp.sv
// ---------------------------------------------------------------------------
// Serial power-of-ten unit
// Turns a log10 value in Q16 into an integer ppm value, one fraction bit
// of the log2 exponent a step, and clamps it to the limit.
// ---------------------------------------------------------------------------
`default_nettype none

module gsp_exp import gsp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [22:0] t,
  input  wire logic [15:0]        limit,
  output logic                    done,
  output logic [15:0]             ppm
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_MUL,
    E_CHK,
    E_STEP,
    E_ACC,
    E_FIN
  } estate_t;

  estate_t            state_r;
  logic               done_r;
  logic signed [22:0] t_r;
  logic signed [41:0] u_r;
  logic [3:0]         k_r;
  logic [15:0]        f_r;
  logic [3:0]         it_r;
  logic [30:0]        pw_r;
  logic [61:0]        mp_r;
  logic [15:0]        ppm_r;
  logic [46:0]        wide;
  logic [16:0]        v;

  // Integer result floor(2^f * 2^k).
  always_comb begin
    wide = {16'b0, pw_r} << k_r;
    v    = wide[46:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        E_IDLE: begin
          if (start) begin
            t_r     <= t;
            state_r <= E_MUL;
          end
        end
        E_MUL: begin
          u_r     <= t_r * LOG2_OF_10;
          state_r <= E_CHK;
        end
        // Out-of-range exponents settle at once.
        E_CHK: begin
          if (u_r[41]) begin
            ppm_r   <= '0;
            done_r  <= 1'b1;
            state_r <= E_IDLE;
          end else if (|u_r[40:36]) begin
            ppm_r   <= limit;
            done_r  <= 1'b1;
            state_r <= E_IDLE;
          end else begin
            k_r     <= u_r[35:32];
            f_r     <= u_r[31:16];
            pw_r    <= 31'd1 << 30;
            it_r    <= '0;
            state_r <= E_STEP;
          end
        end
        E_STEP: begin
          if (f_r[15]) begin
            mp_r    <= pw_r * EXP_FAC[it_r];
            state_r <= E_ACC;
          end else begin
            f_r     <= {f_r[14:0], 1'b0};
            it_r    <= it_r + 1'b1;
            state_r <= (it_r == 4'd15) ? E_FIN : E_STEP;
          end
        end
        E_ACC: begin
          pw_r    <= mp_r[60:30];
          f_r     <= {f_r[14:0], 1'b0};
          it_r    <= it_r + 1'b1;
          state_r <= (it_r == 4'd15) ? E_FIN : E_STEP;
        end
        E_FIN: begin
          ppm_r   <= (v > {1'b0, limit}) ? limit : v[15:0];
          done_r  <= 1'b1;
          state_r <= E_IDLE;
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign ppm  = ppm_r;

endmodule

`default_nettype wire

// File: tb/sv/gas_sensor_ppm_converter_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gas sensor ppm converter core testbench
// Sends calibration and measure requests with random gaps and output
// stalls. A local model of the conversion predicts each result, and every
// result is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------

module gas_sensor_ppm_converter_core_test;
  import gsp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  gsp_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  gsp_out_t    out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: shadow registers and calibration state.
  logic [15:0] reg_shadow [8];
  logic [31:0] cal_total;
  logic [3:0]  cal_taken;
  logic [31:0] ro_ref;
  logic        ro_ready;

  gsp_out_t expected_results [$];
  int       error_count;
  int       hold_cycles;
  bit       stall_quiet;
  int       idle_cycles;

  gas_sensor_ppm_converter_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Truncated integer square root.
  function automatic longint unsigned int_sqrt(input longint unsigned x_in);
    longint unsigned x;
    longint unsigned root;
    longint unsigned bitpos;
    x = x_in;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > x) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (x >= root + bitpos) begin
        x = x - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // Base-10 logarithm of a positive Q16 ratio, result in Q16.
  function automatic longint log10_of_ratio(input longint unsigned r);
    int              msb;
    longint unsigned mant;
    longint          frac;
    longint          lg2;
    msb = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) begin
      if (r[i]) msb = i;
    end
    mant = (msb > 30) ? (r >> (msb - 30)) : (r << (30 - msb));
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    lg2 = longint'(msb - FRAC_BITS) * 65536 + frac;
    return (lg2 * 19728) >>> 16;
  endfunction

  // Power of two of a Q16 exponent; 65536 or more means overflow.
  function automatic longint unsigned exp2_of_q16(input longint u);
    longint          k;
    longint unsigned f;
    longint unsigned prod;
    longint unsigned fac;
    k = u >>> 16;
    f = u - k * 65536;
    prod = 64'd1 << 30;
    fac = 64'd2 << 30;
    if (k < 0) return 0;
    if (k >= 16) return 64'h10000;
    for (int i = 1; i <= 16; i++) begin
      fac = int_sqrt(fac << 30);
      if (f[16 - i]) prod = (prod * fac) >> 30;
    end
    return (prod << k) >> 30;
  endfunction

  // Concentration of one gas along its log-log curve.
  function automatic logic [15:0] gas_concentration(input longint unsigned r,
                                                    input logic [15:0] off,
                                                    input logic [15:0] slp);
    longint          a;
    longint          b;
    longint          m;
    longint          t;
    longint unsigned v;
    logic [15:0]     limit;
    a = longint'($signed(reg_shadow[CFG_INTERCEPT]));
    b = longint'($signed(off));
    m = longint'($signed(slp));
    limit = reg_shadow[CFG_PPM_LIMIT];
    if (m == 0) return limit;
    if (r == 0) return (m < 0) ? limit : 16'd0;
    t = ((log10_of_ratio(r) - b * 16) * 4096) / m + a * 16;
    v = exp2_of_q16((t * 217706) >>> 16);
    return (v > limit) ? limit : v[15:0];
  endfunction

  // Works out the result of one accepted request and updates the state.
  task automatic predict_conversion(input gsp_in_t item);
    gsp_out_t        res;
    longint unsigned ratio;
    longint unsigned total;
    longint unsigned r;
    res = '0;
    if (item.sample == 0) begin
      res.status = ST_ZERO_SAMPLE;
    end else begin
      ratio = (item.sample >= ADC_FULL_SCALE) ? 0 :
              ((longint'(ADC_FULL_SCALE) - item.sample) << FRAC_BITS) / item.sample;
      if (item.operation) begin
        total = longint'(cal_total) + ratio;
        cal_total = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        cal_taken = cal_taken + 1;
        if (cal_taken >= CAL_SAMPLES) begin
          ro_ref = cal_total / CAL_DIVISOR;
          ro_ready = 1'b1;
          cal_total = 0;
          cal_taken = 0;
          res.status = ST_CAL_DONE;
        end else begin
          res.status = ST_CAL_TAKEN;
        end
      end else if (!ro_ready || ro_ref == 0) begin
        res.status = ST_UNCALIBRATED;
      end else begin
        r = (ratio << FRAC_BITS) / ro_ref;
        res.status    = ST_MEASURED;
        res.lpg_ppm   = gas_concentration(r, reg_shadow[CFG_LPG_OFFSET],
                                          reg_shadow[CFG_LPG_SLOPE]);
        res.co_ppm    = gas_concentration(r, reg_shadow[CFG_CO_OFFSET],
                                          reg_shadow[CFG_CO_SLOPE]);
        res.smoke_ppm = gas_concentration(r, reg_shadow[CFG_SMOKE_OFFSET],
                                          reg_shadow[CFG_SMOKE_SLOPE]);
      end
    end
    expected_results.push_back(res);
  endtask

  // Gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
    error_count++;
  endtask

  task automatic check_result(input gsp_out_t got);
    gsp_out_t exp_r;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result status", -1, got.status);
    end else begin
      exp_r = expected_results.pop_front();
      if (got.status !== exp_r.status) report_mismatch("status", exp_r.status, got.status);
      if (got.lpg_ppm !== exp_r.lpg_ppm) report_mismatch("lpg_ppm", exp_r.lpg_ppm, got.lpg_ppm);
      if (got.co_ppm !== exp_r.co_ppm) report_mismatch("co_ppm", exp_r.co_ppm, got.co_ppm);
      if (got.smoke_ppm !== exp_r.smoke_ppm)
        report_mismatch("smoke_ppm", exp_r.smoke_ppm, got.smoke_ppm);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  // Watchdog on cycles in which no request, result or write is accepted.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 20000) begin
      $display("gas_sensor_ppm_converter_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls: random runs, a long hold-off on request.
  initial begin : stall_driver
    int run;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall = 1'b1;
        hold_cycles--;
      end else if (run > 0) begin
        out_stall = 1'b1;
        run--;
      end else if (!stall_quiet && $urandom_range(0, 99) < 30) begin
        out_stall = 1'b1;
        run = pick_gap();
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Sends one request; entered and left at a falling edge.
  task automatic send_request(input logic op, input logic [9:0] smp, input bit no_gap = 0);
    gsp_in_t item;
    int      gap;
    item.operation = op;
    item.sample = smp;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (in_stall);
    predict_conversion(item);
    @(negedge clk);
  endtask

  // Waits until every result has come and the block has settled.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    reg_shadow[idx] = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic calibrate_series(input logic [9:0] lo, input logic [9:0] hi);
    for (int i = 0; i < CAL_SAMPLES; i++) send_request(1'b1, $urandom_range(lo, hi));
  endtask

  // Edge cases with the reset curves.
  task automatic test_directed();
    send_request(1'b0, 10'd512);
    send_request(1'b0, 10'd0);
    send_request(1'b1, 10'd0);
    // A series of full-scale samples leaves the reference at zero.
    for (int i = 0; i < CAL_SAMPLES; i++) send_request(1'b1, 10'd1023);
    send_request(1'b0, 10'd300);
    calibrate_series(10'd200, 10'd800);
    send_request(1'b0, 10'd1);
    send_request(1'b0, 10'd1022);
    send_request(1'b0, 10'd1023);
    send_request(1'b0, 10'd512);
    send_request(1'b0, 10'd0);
  endtask

  // Register extremes: zero and positive slopes, clamp limits, wide offsets.
  task automatic test_register_extremes();
    wait_idle();
    write_register(CFG_LPG_SLOPE, 16'd0);
    write_register(CFG_CO_SLOPE, 16'd1500);
    write_register(CFG_SMOKE_SLOPE, 16'h8000);
    write_register(CFG_PPM_LIMIT, 16'hFFFF);
    write_register(CFG_INTERCEPT, 16'h7FFF);
    write_register(CFG_LPG_OFFSET, 16'h8000);
    write_register(CFG_CO_OFFSET, 16'h7FFF);
    write_register(CFG_SMOKE_OFFSET, 16'd0);
    foreach (reg_shadow[i]) ;
    send_request(1'b0, 10'd1);
    send_request(1'b0, 10'd1023);
    send_request(1'b0, 10'd700);
    wait_idle();
    write_register(CFG_PPM_LIMIT, 16'd0);
    write_register(CFG_INTERCEPT, 16'h8000);
    write_register(CFG_SMOKE_SLOPE, 16'h7FFF);
    send_request(1'b0, 10'd100);
    send_request(1'b0, 10'd1023);
  endtask

  // Random slope: mostly in the usual negative range, sometimes anything.
  function automatic logic [15:0] pick_slope();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return -16'($urandom_range(800, 3000));
    if (roll < 80) return 16'($urandom_range(800, 3000));
    if (roll < 85) return 16'd0;
    return 16'($urandom);
  endfunction

  task automatic randomise_registers();
    wait_idle();
    write_register(CFG_INTERCEPT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                  : 16'($urandom_range(4000, 14000)));
    write_register(CFG_LPG_OFFSET, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                   : 16'($urandom_range(0, 4000)));
    write_register(CFG_LPG_SLOPE, pick_slope());
    write_register(CFG_CO_OFFSET, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                  : 16'($urandom_range(0, 4000)));
    write_register(CFG_CO_SLOPE, pick_slope());
    write_register(CFG_SMOKE_OFFSET, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 4000)));
    write_register(CFG_SMOKE_SLOPE, pick_slope());
    write_register(CFG_PPM_LIMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                  : 16'($urandom_range(1000, 65535)));
  endtask

  // Random sample with extra weight on the ends of the range.
  function automatic logic [9:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 10'd0;
    if (roll < 8) return 10'd1023;
    if (roll < 12) return 10'($urandom_range(1, 8));
    return 10'($urandom);
  endfunction

  // Phases of calibration series and measurements under random registers.
  task automatic test_random_traffic();
    int sent;
    sent = 0;
    stall_quiet = 1'b0;
    for (int phase = 0; phase < 10; phase++) begin
      randomise_registers();
      stall_quiet = (phase == 3);
      if ($urandom_range(0, 3) != 0) begin
        calibrate_series(10'($urandom_range(1, 500)), 10'($urandom_range(500, 1023)));
        sent += CAL_SAMPLES;
      end
      for (int i = 0; i < 45; i++) begin
        send_request(($urandom_range(0, 9) == 0), pick_sample(), stall_quiet);
        sent++;
      end
    end
    stall_quiet = 1'b0;
  endtask

  // Long receiver hold-off while requests keep coming.
  task automatic test_backpressure();
    wait_idle();
    write_register(CFG_PPM_LIMIT, RST_PPM_LIMIT);
    hold_cycles = 1500;
    for (int i = 0; i < 12; i++) send_request(1'b0, pick_sample(), 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    error_count = 0;
    hold_cycles = 0;
    stall_quiet = 1'b0;
    idle_cycles = 0;
    reg_shadow[CFG_INTERCEPT]    = RST_INTERCEPT;
    reg_shadow[CFG_LPG_OFFSET]   = RST_LPG_OFFSET;
    reg_shadow[CFG_LPG_SLOPE]    = RST_LPG_SLOPE;
    reg_shadow[CFG_CO_OFFSET]    = RST_CO_OFFSET;
    reg_shadow[CFG_CO_SLOPE]     = RST_CO_SLOPE;
    reg_shadow[CFG_SMOKE_OFFSET] = RST_SMOKE_OFFSET;
    reg_shadow[CFG_SMOKE_SLOPE]  = RST_SMOKE_SLOPE;
    reg_shadow[CFG_PPM_LIMIT]    = RST_PPM_LIMIT;
    cal_total = '0;
    cal_taken = '0;
    ro_ref = '0;
    ro_ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();

    // Drain and settle.
    wait_idle();
    repeat (500) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("gas_sensor_ppm_converter_core verification clean");
    end else begin
      $display("gas_sensor_ppm_converter_core verification failed");
    end
    $finish;
  end

endmodule
